// File: hdl/pau_pkg.sv
// ----------------------------------------------------------------------------
// Polynomial arithmetic unit package
// Command codes, cell operation codes and the shared saturation helper.
// ----------------------------------------------------------------------------
package pau_pkg;

   typedef enum logic [2:0] {
      CMD_LOAD  = 3'd0,
      CMD_ADD   = 3'd1,
      CMD_SUB   = 3'd2,
      CMD_MUL   = 3'd3,
      CMD_SCALE = 3'd4,
      CMD_ADDC  = 3'd5,
      CMD_EVAL  = 3'd6,
      CMD_READ  = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      ACC_HOLD   = 2'd0,
      ACC_FWD    = 2'd1,
      ACC_BWD    = 2'd2,
      ACC_COMMIT = 2'd3
   } acc_op_type;

   typedef enum logic [1:0] {
      PROD_HOLD = 2'd0,
      PROD_FWD  = 2'd1,
      PROD_ZERO = 2'd2,
      PROD_COPY = 2'd3
   } prod_op_type;

   typedef struct packed {
      acc_op_type  acc_op;
      prod_op_type prod_op;
   } cell_ctrl_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic               ovf;
   } sat_type;

   localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
   localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

   // clamp an exact sum to 32 bits and flag the clamp
   function automatic sat_type sat32(input logic signed [65:0] x);
      sat_type r;
      if (x > SAT_MAX) begin
         r.value = 32'sh7FFFFFFF;
         r.ovf   = 1'b1;
      end else if (x < SAT_MIN) begin
         r.value = 32'sh80000000;
         r.ovf   = 1'b1;
      end else begin
         r.value = x[31:0];
         r.ovf   = 1'b0;
      end
      return r;
   endfunction

endpackage

// File: hdl/pau_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one command with its operand.
// ----------------------------------------------------------------------------
interface pau_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         command;
   logic signed [31:0] operand_value;
   logic               operand_last;

   modport source(output valid, command, operand_value, operand_last, input ready);
   modport sink(input valid, command, operand_value, operand_last, output ready);
endinterface

// File: hdl/pau_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one result value with status.
// ----------------------------------------------------------------------------
interface pau_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] result_value;
   logic [6:0]         term_count;
   logic               result_last;
   logic               overflow;

   modport source(output valid, result_value, term_count, result_last, overflow,
                  input ready);
   modport sink(input valid, result_value, term_count, result_last, overflow,
                output ready);
endinterface

// File: hdl/polynomial_arithmetic_unit_top.sv
// ----------------------------------------------------------------------------
// Polynomial arithmetic unit
// Accumulator polynomial held in a ring of coefficient cells, with one shared
// multiplier at the ring head.
// ----------------------------------------------------------------------------
// The accumulator and product buffer live in a ring of MAX_TERMS cells; every
// command walks the ring past the head, where one multiplier and adder work
// on the coefficient in front. One request is handled at a time. A multiply
// coefficient passes each term through the registered multiplier, rounding
// and add in turn; the request with last then commits the product and trims
// trailing zeros. A read also waits on any response stall.
// ----------------------------------------------------------------------------
module polynomial_arithmetic_unit_top
   import pau_pkg::*;
#(
   parameter int MAX_TERMS     = 64,
   parameter int FRACTION_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   pau_req_if.sink   req_chan,
   pau_rsp_if.source rsp_chan
);

   localparam int CW = $clog2(MAX_TERMS + 1);
   localparam int LW = CW + 1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_ALIGN, ST_WALK, ST_RETURN, ST_COMMIT, ST_SCAN,
      ST_SCALE, ST_ADDC, ST_EVAL, ST_READ, ST_EMIT
   } state_type;

   state_type          state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic signed [31:0] v_ff, v_in;
   logic               last_ff, last_in;
   logic [CW-1:0]      j_ff, j_in;
   logic [CW-1:0]      held_ff, held_in;
   logic               ovf_ff, ovf_in;
   logic [CW-1:0]      step_ff, step_in;
   logic [1:0]         sub_ff, sub_in;
   logic [CW-1:0]      nz_ff, nz_in;
   logic signed [31:0] r_ff, r_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_value_ff, rsp_value_in;
   logic [6:0]         rsp_count_ff, rsp_count_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_ovf_ff, rsp_ovf_in;

   logic signed [31:0] acc_q  [MAX_TERMS];
   logic signed [31:0] prod_q [MAX_TERMS];
   cell_ctrl_type      ctrl;
   logic signed [31:0] acc_tail, prod_tail;
   logic [CW-1:0]      commit_len;

   logic               mul_en, rnd_en;
   logic signed [31:0] mac_a, mac_addend;
   sat_type            mac_sum;

   logic signed [31:0] acc_head, prod_head;
   logic [CW-1:0]      align_amt, ret_amt, scan_nz, scale_nz;
   logic               step_last, in_held, fits, j_full, out_free;
   sat_type            addsub_sat, addc_sat;
   logic [LW-1:0]      len_raw, len_clamped;
   cmd_type            req_cmd;

   for (genvar k = 0; k < MAX_TERMS; k++) begin : g_cell
      pau_cell #(
         .INDEX (k),
         .LEN_W (CW)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .acc_fwd    ((k == MAX_TERMS - 1) ? acc_tail : acc_q[(k + 1) % MAX_TERMS]),
         .acc_bwd    (acc_q[(k + MAX_TERMS - 1) % MAX_TERMS]),
         .prod_fwd   ((k == MAX_TERMS - 1) ? prod_tail : prod_q[(k + 1) % MAX_TERMS]),
         .commit_len (commit_len),
         .acc        (acc_q[k]),
         .prod       (prod_q[k])
      );
   end

   pau_mac #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_mac (
      .clock  (clock),
      .mul_en (mul_en),
      .rnd_en (rnd_en),
      .a      (mac_a),
      .b      (v_ff),
      .addend (mac_addend),
      .sum    (mac_sum)
   );

   assign acc_head  = acc_q[0];
   assign prod_head = prod_q[0];
   assign req_cmd   = cmd_type'(req_chan.command);

   always_comb begin
      j_full    = (j_ff == CW'(MAX_TERMS));
      align_amt = j_full ? '0 : j_ff;
      ret_amt   = (align_amt == '0) ? '0 : CW'(MAX_TERMS) - align_amt;
      step_last = (step_ff == CW'(MAX_TERMS - 1));
      in_held   = (step_ff < held_ff);
      fits      = (LW'(step_ff) + LW'(j_ff)) < LW'(MAX_TERMS);
      out_free  = !rsp_valid_ff || rsp_chan.ready;
      scan_nz   = (acc_head != '0) ? step_ff + CW'(1) : nz_ff;
      scale_nz  = (mac_sum.value != '0) ? step_ff + CW'(1) : nz_ff;
      addc_sat  = sat32(66'(acc_head) + 66'(v_ff));
      if (cmd_ff == CMD_SUB) begin
         addsub_sat = sat32(66'(prod_head) - 66'(v_ff));
      end else begin
         addsub_sat = sat32(66'(prod_head) + 66'(v_ff));
      end
      case (cmd_ff)
         CMD_LOAD: len_raw = LW'(j_ff) + LW'(1);
         CMD_MUL:  len_raw = LW'(held_ff) + LW'(j_ff);
         default:  len_raw = (LW'(held_ff) > LW'(j_ff) + LW'(1)) ? LW'(held_ff)
                                                                 : LW'(j_ff) + LW'(1);
      endcase
      len_clamped = (len_raw > LW'(MAX_TERMS)) ? LW'(MAX_TERMS) : len_raw;
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      v_in         = v_ff;
      last_in      = last_ff;
      j_in         = j_ff;
      held_in      = held_ff;
      ovf_in       = ovf_ff;
      step_in      = step_ff;
      sub_in       = sub_ff;
      nz_in        = nz_ff;
      r_in         = r_ff;
      rsp_valid_in = rsp_chan.ready ? 1'b0 : rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_count_in = rsp_count_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      ctrl.acc_op  = ACC_HOLD;
      ctrl.prod_op = PROD_HOLD;
      acc_tail     = acc_head;
      prod_tail    = prod_head;
      commit_len   = CW'(len_clamped);
      mul_en       = 1'b0;
      rnd_en       = 1'b0;
      mac_a        = acc_head;
      mac_addend   = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               cmd_in  = req_cmd;
               v_in    = req_chan.operand_value;
               last_in = req_chan.operand_last;
               step_in = '0;
               sub_in  = '0;
               nz_in   = '0;
               r_in    = '0;
               case (req_cmd)
                  CMD_LOAD, CMD_ADD, CMD_SUB, CMD_MUL: begin
                     // first coefficient of a stream sets up the product buffer
                     if (j_ff == '0) begin
                        ctrl.prod_op = (req_cmd == CMD_ADD || req_cmd == CMD_SUB)
                                       ? PROD_COPY : PROD_ZERO;
                     end
                     state_in = ST_ALIGN;
                  end
                  CMD_SCALE: begin
                     j_in     = '0;
                     state_in = ST_SCALE;
                  end
                  CMD_ADDC: begin
                     j_in     = '0;
                     state_in = ST_ADDC;
                  end
                  CMD_EVAL: begin
                     j_in     = '0;
                     state_in = ST_EVAL;
                  end
                  default: begin
                     j_in     = '0;
                     state_in = ST_READ;
                  end
               endcase
            end
         end

         ST_ALIGN: begin
            // rotate the product ring so entry j sits at the head
            if (step_ff == align_amt) begin
               step_in  = '0;
               sub_in   = '0;
               state_in = ST_WALK;
            end else begin
               ctrl.prod_op = PROD_FWD;
               step_in      = step_ff + CW'(1);
            end
         end

         ST_WALK: begin
            if (cmd_ff == CMD_MUL) begin
               mul_en     = (sub_ff == 2'd0);
               rnd_en     = (sub_ff == 2'd1);
               mac_addend = prod_head;
               if (sub_ff != 2'd2) begin
                  sub_in = sub_ff + 2'd1;
               end else begin
                  sub_in = '0;
                  if (in_held && fits) begin
                     prod_tail = mac_sum.value;
                     ovf_in    = ovf_ff | mac_sum.ovf;
                  end else if (in_held && acc_head != '0 && v_ff != '0) begin
                     ovf_in = 1'b1;
                  end
                  ctrl.acc_op  = ACC_FWD;
                  ctrl.prod_op = PROD_FWD;
                  if (step_last) begin
                     step_in  = '0;
                     state_in = ST_RETURN;
                  end else begin
                     step_in = step_ff + CW'(1);
                  end
               end
            end else begin
               if (step_ff == '0) begin
                  if (!j_full) begin
                     if (cmd_ff == CMD_LOAD) begin
                        prod_tail = v_ff;
                     end else begin
                        prod_tail = addsub_sat.value;
                        ovf_in    = ovf_ff | addsub_sat.ovf;
                     end
                  end else if (v_ff != '0) begin
                     ovf_in = 1'b1;
                  end
               end
               ctrl.acc_op  = ACC_FWD;
               ctrl.prod_op = PROD_FWD;
               if (step_last) begin
                  step_in  = '0;
                  state_in = ST_RETURN;
               end else begin
                  step_in = step_ff + CW'(1);
               end
            end
         end

         ST_RETURN: begin
            if (step_ff == ret_amt) begin
               step_in = '0;
               if (last_ff) begin
                  state_in = ST_COMMIT;
               end else begin
                  j_in     = j_full ? j_ff : j_ff + CW'(1);
                  state_in = ST_IDLE;
               end
            end else begin
               ctrl.prod_op = PROD_FWD;
               step_in      = step_ff + CW'(1);
            end
         end

         ST_COMMIT: begin
            ctrl.acc_op = ACC_COMMIT;
            j_in        = '0;
            step_in     = '0;
            nz_in       = '0;
            state_in    = ST_SCAN;
         end

         ST_SCAN: begin
            // find the highest nonzero coefficient
            ctrl.acc_op = ACC_FWD;
            nz_in       = scan_nz;
            if (step_last) begin
               held_in  = (scan_nz == '0) ? CW'(1) : scan_nz;
               step_in  = '0;
               state_in = ST_EMIT;
            end else begin
               step_in = step_ff + CW'(1);
            end
         end

         ST_SCALE: begin
            mul_en = (sub_ff == 2'd0);
            rnd_en = (sub_ff == 2'd1);
            if (sub_ff != 2'd2) begin
               sub_in = sub_ff + 2'd1;
            end else begin
               sub_in      = '0;
               acc_tail    = mac_sum.value;
               ovf_in      = ovf_ff | mac_sum.ovf;
               ctrl.acc_op = ACC_FWD;
               nz_in       = scale_nz;
               if (step_last) begin
                  held_in  = (scale_nz == '0) ? CW'(1) : scale_nz;
                  step_in  = '0;
                  state_in = ST_EMIT;
               end else begin
                  step_in = step_ff + CW'(1);
               end
            end
         end

         ST_ADDC: begin
            ctrl.acc_op = ACC_FWD;
            if (step_ff == '0) begin
               acc_tail = addc_sat.value;
               ovf_in   = ovf_ff | addc_sat.ovf;
            end
            if (step_last) begin
               step_in  = '0;
               state_in = ST_EMIT;
            end else begin
               step_in = step_ff + CW'(1);
            end
         end

         ST_EVAL: begin
            // walk the ring backward so coefficients arrive highest first
            mac_a      = r_ff;
            mac_addend = acc_head;
            mul_en     = (sub_ff == 2'd0);
            rnd_en     = (sub_ff == 2'd1);
            if (sub_ff == 2'd0) begin
               ctrl.acc_op = ACC_BWD;
            end
            if (sub_ff != 2'd2) begin
               sub_in = sub_ff + 2'd1;
            end else begin
               sub_in = '0;
               r_in   = mac_sum.value;
               ovf_in = ovf_ff | mac_sum.ovf;
               if (step_last) begin
                  step_in  = '0;
                  state_in = ST_EMIT;
               end else begin
                  step_in = step_ff + CW'(1);
               end
            end
         end

         ST_READ: begin
            if (!in_held || out_free) begin
               if (in_held) begin
                  rsp_valid_in = 1'b1;
                  rsp_value_in = acc_head;
                  rsp_count_in = 7'(held_ff);
                  rsp_last_in  = (step_ff == held_ff - CW'(1));
                  rsp_ovf_in   = ovf_ff;
               end
               ctrl.acc_op = ACC_FWD;
               if (step_last) begin
                  step_in  = '0;
                  state_in = ST_IDLE;
               end else begin
                  step_in = step_ff + CW'(1);
               end
            end
         end

         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = (cmd_ff == CMD_EVAL) ? r_ff : '0;
               rsp_count_in = 7'(held_ff);
               rsp_last_in  = 1'b1;
               rsp_ovf_in   = ovf_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         j_ff         <= '0;
         held_ff      <= CW'(1);
         ovf_ff       <= 1'b0;
         step_ff      <= '0;
         sub_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         j_ff         <= j_in;
         held_ff      <= held_in;
         ovf_ff       <= ovf_in;
         step_ff      <= step_in;
         sub_ff       <= sub_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      v_ff         <= v_in;
      last_ff      <= last_in;
      nz_ff        <= nz_in;
      r_ff         <= r_in;
      rsp_value_ff <= rsp_value_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.result_value = rsp_value_ff;
   assign rsp_chan.term_count   = rsp_count_ff;
   assign rsp_chan.result_last  = rsp_last_ff;
   assign rsp_chan.overflow     = rsp_ovf_ff;

endmodule

// File: hdl/pau_cell.sv
// ----------------------------------------------------------------------------
// Coefficient cell
// Holds one accumulator coefficient and one product buffer coefficient and
// shifts them along the ring, or commits the product into the accumulator.
// ----------------------------------------------------------------------------
module pau_cell
   import pau_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int LEN_W = 7
) (
   input  logic               clock,
   input  logic               reset,
   input  cell_ctrl_type      ctrl,
   input  logic signed [31:0] acc_fwd,
   input  logic signed [31:0] acc_bwd,
   input  logic signed [31:0] prod_fwd,
   input  logic [LEN_W-1:0]   commit_len,
   output logic signed [31:0] acc,
   output logic signed [31:0] prod
);

   logic signed [31:0] acc_ff, acc_in;
   logic signed [31:0] prod_ff, prod_in;

   always_comb begin
      case (ctrl.acc_op)
         ACC_FWD:    acc_in = acc_fwd;
         ACC_BWD:    acc_in = acc_bwd;
         ACC_COMMIT: acc_in = (LEN_W'(INDEX) < commit_len) ? prod_ff : '0;
         default:    acc_in = acc_ff;
      endcase
      case (ctrl.prod_op)
         PROD_FWD:  prod_in = prod_fwd;
         PROD_ZERO: prod_in = '0;
         PROD_COPY: prod_in = acc_ff;
         default:   prod_in = prod_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign acc  = acc_ff;
   assign prod = prod_ff;

endmodule

// File: hdl/pau_mac.sv
// ----------------------------------------------------------------------------
// Shared multiply unit
// Registered product, registered round-to-nearest shift, then a saturating
// add of the addend.
// ----------------------------------------------------------------------------
module pau_mac
   import pau_pkg::*;
#(
   parameter int FRACTION_BITS = 16
) (
   input  logic               clock,
   input  logic               mul_en,
   input  logic               rnd_en,
   input  logic signed [31:0] a,
   input  logic signed [31:0] b,
   input  logic signed [31:0] addend,
   output sat_type            sum
);

   localparam logic signed [63:0] HALF = 64'sd1 <<< FRACTION_BITS >>> 1;

   logic signed [63:0] p_ff;
   logic signed [63:0] q_ff;

   always_ff @(posedge clock) begin
      if (mul_en) begin
         p_ff <= 64'(a) * 64'(b);
      end
      if (rnd_en) begin
         q_ff <= (p_ff + HALF) >>> FRACTION_BITS;
      end
   end

   assign sum = sat32(66'(q_ff) + 66'(addend));

endmodule
